/* rtl/civil_date_time_to_epoch_assert.svh */
// assertion macros shared by the checker
`ifndef CIVIL_DATE_TIME_TO_EPOCH_ASSERT_SVH
`define CIVIL_DATE_TIME_TO_EPOCH_ASSERT_SVH

// same-cycle implication, off during reset
`define CCTE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("ccte assertion failed");

// next-cycle implication, off during reset
`define CCTE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ccte assertion failed");

// next-cycle implication, live during reset
`define CCTE_ASSERT_RESET(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) (pre) |=> (post)) \
    else $error("ccte assertion failed");

`endif

/* rtl/ccte_pkg.sv */
`default_nettype none

package ccte_pkg;

  localparam logic [4:0] TsLen   = 5'd19;
  localparam logic [4:0] DateLen = 5'd10;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // floor(y / 400) as (y * EraRecip) >> EraShift, exact for 14-bit y
  localparam logic [12:0] EraRecip = 13'd5243;
  localparam int unsigned EraShift = 21;
  // floor(yoe / 100) as (yoe * CentRecip) >> CentShift, exact for yoe < 400
  localparam logic [5:0] CentRecip = 6'd41;
  localparam int unsigned CentShift = 12;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StShort    = 2'd1,
    StBadDigit = 2'd2,
    StMonth    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FldNone, FldYear, FldMonth, FldDay, FldHour, FldMin, FldSec
  } digit_fld_e;

  typedef enum logic [2:0] {
    BkIdle, BkEra, BkYoe, BkDoe, BkDays, BkMul, BkFin
  } back_state_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       field_end;
  } in_req_t;

  typedef struct packed {
    logic signed [38:0] epoch_value;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        fmt;
    status_e     status;
  } job_t;

  function automatic digit_fld_e digit_field(input logic [4:0] pos);
    digit_fld_e fld;
    if (pos inside {[5'd0:5'd3]}) fld = FldYear;
    else if (pos inside {5'd5, 5'd6}) fld = FldMonth;
    else if (pos inside {5'd8, 5'd9}) fld = FldDay;
    else if (pos inside {5'd11, 5'd12}) fld = FldHour;
    else if (pos inside {5'd14, 5'd15}) fld = FldMin;
    else if (pos inside {5'd17, 5'd18}) fld = FldSec;
    else fld = FldNone;
    return fld;
  endfunction

  // days before the first of the month, year starting in march
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

/* rtl/civil_date_time_to_epoch.sv */
// Parses a date (YYYY-MM-DD) or timestamp (YYYY-MM-DD HH:MM:SS) field one character
// per request and returns, per field end, days or seconds since 1970-01-01 with a
// status code. The front parser takes one character every cycle unless the queue is
// full; each finished field goes through a two-entry queue into a calendar converter
// that takes one field at a time: the queue pop, five arithmetic steps and the result
// load, which waits for a free output register. full rises when fields end faster than
// the converter finishes them or while results are not popped. A result waits in an
// output register while the converter works on the next field. field_format is written
// through cfg_we_i/cfg_wdata_i by the user only while the block is idle; not enforced.

`default_nettype none

module civil_date_time_to_epoch import ccte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  input  in_req_t in_req_i,
  output logic    full,
  input  logic    pop,
  output result_t res_o,
  output logic    empty,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i
);

  logic fmt_q;
  logic accept;
  logic job_push;
  job_t job_in, job_out;
  logic q_full, q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  ccte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (in_req_i),
    .fmt_i      (fmt_q),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  ccte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ccte_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .job_i     (job_out),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .res_o     (res_o),
    .empty_o   (empty)
  );

endmodule

`default_nettype wire

/* rtl/ccte_front.sv */
`default_nettype none

module ccte_front import ccte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  in_req_t req_i,
  input  logic    fmt_i,
  output logic    job_push_o,
  output job_t    job_o
);

  logic [4:0]  pos_q, pos_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d, day_q, day_d;
  logic [6:0]  hour_q, hour_d, min_q, min_d, sec_q, sec_d;
  logic        bad_q, bad_d;

  logic [4:0]  lim;
  logic [3:0]  dval;
  logic        is_digit;
  digit_fld_e  fld;
  status_e     status;

  always_comb begin
    pos_d      = pos_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    hour_d     = hour_q;
    min_d      = min_q;
    sec_d      = sec_q;
    bad_d      = bad_q;
    job_push_o = 1'b0;
    lim        = fmt_i ? TsLen : DateLen;
    dval       = 4'(req_i.char_byte - CharZero);
    is_digit   = req_i.char_byte inside {[CharZero:CharNine]};
    fld        = digit_field(pos_q);

    if (accept_i && req_i.has_char) begin
      if ((pos_q < lim) && (fld != FldNone)) begin
        if (!is_digit) begin
          bad_d = 1'b1;
        end else begin
          case (fld)
            FldYear:  year_d  = year_q * 14'd10 + 14'(dval);
            FldMonth: month_d = month_q * 7'd10 + 7'(dval);
            FldDay:   day_d   = day_q * 7'd10 + 7'(dval);
            FldHour:  hour_d  = hour_q * 7'd10 + 7'(dval);
            FldMin:   min_d   = min_q * 7'd10 + 7'(dval);
            FldSec:   sec_d   = sec_q * 7'd10 + 7'(dval);
            default:  ;
          endcase
        end
      end
      if (pos_q < TsLen) pos_d = pos_q + 5'd1;
    end

    // too short beats bad digit, which beats bad month
    if (pos_d < lim) status = StShort;
    else if (bad_d) status = StBadDigit;
    else if ((month_d < 7'd1) || (month_d > 7'd12)) status = StMonth;
    else status = StOk;

    job_o.year   = year_d;
    job_o.month  = month_d;
    job_o.day    = day_d;
    job_o.hour   = hour_d;
    job_o.minute = min_d;
    job_o.second = sec_d;
    job_o.fmt    = fmt_i;
    job_o.status = status;

    if (accept_i && req_i.field_end) begin
      job_push_o = 1'b1;
      pos_d   = '0;
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
      bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      bad_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      bad_q   <= bad_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/ccte_queue.sv */
`default_nettype none

module ccte_queue import ccte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

/* rtl/ccte_back.sv */
`default_nettype none

module ccte_back import ccte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  job_t    job_i,
  output logic    q_pop_o,
  input  logic    pop_i,
  output result_t res_o,
  output logic    empty_o
);

  back_state_e state_q, state_d;
  logic        load;
  logic        out_free;

  job_t               job_q;
  logic signed [14:0] ym1;
  logic [26:0]        era_prod;
  logic signed [14:0] ym1_q;
  logic signed [6:0]  era_q;
  logic signed [10:0] doy_q;
  logic signed [15:0] yoe_full;
  logic [8:0]         yoe_q;
  logic signed [23:0] era146_q;
  logic [17:0]        yoe365;
  logic [14:0]        cent_prod;
  logic [18:0]        doe_u;
  logic signed [18:0] doe_q;
  logic signed [23:0] days_q;
  logic signed [38:0] mul_q;
  logic [18:0]        hms_q;
  logic signed [38:0] value;

  logic    res_valid_q;
  result_t res_q;

  assign out_free = !res_valid_q || pop_i;
  assign empty_o  = !res_valid_q;
  assign res_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = BkEra;
        end
      end
      BkEra:  state_d = BkYoe;
      BkYoe:  state_d = BkDoe;
      BkDoe:  state_d = BkDays;
      BkDays: state_d = BkMul;
      BkMul:  state_d = BkFin;
      BkFin: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // year counted from march, so jan and feb belong to the year before
  assign ym1 = $signed({1'b0, job_q.year}) - ((job_q.month <= 7'd2) ? 15'sd1 : 15'sd0);
  assign era_prod  = 27'(ym1[13:0]) * 27'(EraRecip);
  assign yoe_full  = 16'(ym1_q) - era_q * 16'sd400;
  assign yoe365    = 18'(yoe_q) * 18'd365;
  assign cent_prod = 15'(yoe_q) * 15'(CentRecip);
  assign doe_u     = 19'(yoe365) + 19'(yoe_q[8:2]) - 19'(cent_prod >> CentShift);

  always_comb begin
    if (job_q.status != StOk) value = '0;
    else if (job_q.fmt) value = mul_q + $signed({20'b0, hms_q});
    else value = 39'(days_q);
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= job_i;
    case (state_q)
      BkEra: begin
        ym1_q <= ym1;
        era_q <= ym1[14] ? -7'sd1 : $signed({1'b0, era_prod[26:EraShift]});
        doy_q <= $signed({2'b0, month_offset(job_q.month[3:0])})
               + $signed({4'b0, job_q.day}) - 11'sd1;
      end
      BkYoe: begin
        yoe_q    <= yoe_full[8:0];
        era146_q <= era_q * 24'sd146097;
      end
      BkDoe:  doe_q <= $signed(doe_u) + 19'(doy_q);
      BkDays: days_q <= era146_q + 24'(doe_q) - 24'sd719468;
      BkMul: begin
        mul_q <= days_q * 39'sd86400;
        hms_q <= 19'(job_q.hour) * 19'd3600 + 19'(job_q.minute) * 19'd60
               + 19'(job_q.second);
      end
      default: ;
    endcase
    if (load) begin
      res_q.epoch_value <= value;
      res_q.status      <= job_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/ccte_checker.sv */
`default_nettype none

`include "civil_date_time_to_epoch_assert.svh"

module ccte_checker import ccte_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    full,
  input logic    pop,
  input result_t res_o,
  input logic    empty
);

  logic res_in_range;

  assign res_in_range = (res_o.epoch_value >= -39'sd62167305600)
                     && (res_o.epoch_value <= 39'sd253408452039);

  `CCTE_ASSERT_RESET(a_reset_idle, !rst_ni, empty && !full)
  `CCTE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(res_o))
  `CCTE_ASSERT_NOW(a_error_zero, !empty && (res_o.status != StOk), res_o.epoch_value == '0)
  `CCTE_ASSERT_NOW(a_ok_range, !empty && (res_o.status == StOk), res_in_range)

endmodule

bind civil_date_time_to_epoch ccte_checker u_ccte_checker (.*);

`default_nettype wire

/* tb/ccte_epoch_checker.sv */
module ccte_epoch_checker import ccte_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  input  in_req_t in_req_i,
  input  logic    full,
  input  logic    pop,
  input  result_t res_i,
  input  logic    empty,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  output int      n_fail_o,
  output int      n_due_o,
  output int      n_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        fmt_q;
  logic [4:0]  pos_q;
  logic [13:0] year_q;
  logic [6:0]  month_q;
  logic [6:0]  day_q;
  logic [6:0]  hour_q;
  logic [6:0]  minute_q;
  logic [6:0]  second_q;
  logic        bad_q;
  result_t     due_results[$];
  result_t     want_r;

  task automatic clear_field();
    pos_q    = '0;
    year_q   = '0;
    month_q  = '0;
    day_q    = '0;
    hour_q   = '0;
    minute_q = '0;
    second_q = '0;
    bad_q    = 1'b0;
  endtask

  // proleptic gregorian, day added linearly
  function automatic longint civil_day_count(input longint y, input longint m,
                                             input longint d);
    longint era;
    longint yoe;
    longint doy;
    longint doe;
    longint mp;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic parse_request(input in_req_t r);
    digit_fld_e fld;
    logic [4:0] lim;
    logic [3:0] dig;
    logic       is_digit;
    status_e    st;
    longint     val;
    result_t    res;
    if (r.has_char) begin
      lim      = fmt_q ? TsLen : DateLen;
      is_digit = (r.char_byte >= CharZero) && (r.char_byte <= CharNine);
      dig      = 4'(r.char_byte - CharZero);
      case (pos_q)
        5'd0, 5'd1, 5'd2, 5'd3: fld = FldYear;
        5'd5, 5'd6:             fld = FldMonth;
        5'd8, 5'd9:             fld = FldDay;
        5'd11, 5'd12:           fld = FldHour;
        5'd14, 5'd15:           fld = FldMin;
        5'd17, 5'd18:           fld = FldSec;
        default:                fld = FldNone;
      endcase
      if (fld != FldNone && pos_q < lim) begin
        if (!is_digit) begin
          bad_q = 1'b1;
        end else begin
          case (fld)
            FldYear:  year_q   = 14'(year_q * 10 + dig);
            FldMonth: month_q  = 7'(month_q * 10 + dig);
            FldDay:   day_q    = 7'(day_q * 10 + dig);
            FldHour:  hour_q   = 7'(hour_q * 10 + dig);
            FldMin:   minute_q = 7'(minute_q * 10 + dig);
            default:  second_q = 7'(second_q * 10 + dig);
          endcase
        end
      end
      if (pos_q < TsLen) pos_q = pos_q + 5'd1;
    end
    if (r.field_end) begin
      val = 0;
      st  = StOk;
      if (pos_q < (fmt_q ? TsLen : DateLen)) begin
        st = StShort;
      end else if (bad_q) begin
        st = StBadDigit;
      end else if (month_q < 7'd1 || month_q > 7'd12) begin
        st = StMonth;
      end else begin
        val = civil_day_count(longint'(year_q), longint'(month_q), longint'(day_q));
        if (fmt_q) begin
          val = val * 86400 + longint'(hour_q) * 3600 + longint'(minute_q) * 60
              + longint'(second_q);
        end
      end
      res.epoch_value = val[38:0];
      res.status      = st;
      due_results = {due_results, res};
      clear_field();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q = 1'b0;
      clear_field();
      due_results.delete();
      n_due_o     = 0;
      n_fail_o    = 0;
      n_checked_o = 0;
    end else begin
      // pop side first so a request in the same cycle never matches
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          n_fail_o++;
          $display("%0t: result %0d status %0d with nothing expected",
                   $time, res_i.epoch_value, res_i.status);
        end else begin
          want_r = due_results.pop_front();
          n_checked_o++;
          if (res_i.epoch_value !== want_r.epoch_value) begin
            n_fail_o++;
            $display("%0t: epoch_value expected %0d got %0d",
                     $time, want_r.epoch_value, res_i.epoch_value);
          end
          if (res_i.status !== want_r.status) begin
            n_fail_o++;
            $display("%0t: status expected %0d got %0d",
                     $time, want_r.status, res_i.status);
          end
        end
      end
      if (push && !full) parse_request(in_req_i);
      if (cfg_we_i) fmt_q = cfg_wdata_i;
      n_due_o = due_results.size();
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccte_pkg::*;

  localparam int DrainCycles = 32;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 200000;

  logic    clk_i     = 1'b0;
  logic    rst_ni    = 1'b0;
  logic    push      = 1'b0;
  in_req_t in_req    = '0;
  logic    full;
  logic    pop       = 1'b0;
  result_t res;
  logic    empty;
  logic    cfg_we    = 1'b0;
  logic    cfg_wdata = 1'b0;

  int n_fail;
  int n_due;
  int n_checked;

  int   sender_idle_pct = 0;
  int   stall_pct       = 0;
  int   hold_asked      = 0;
  int   hold_done       = 0;
  int   hold_left       = 0;
  int   n_items         = 0;
  int   n_fields        = 0;
  int   cycles          = 0;
  logic cur_fmt         = 1'b0;
  logic [7:0] field_txt[$];

  civil_date_time_to_epoch i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_req_i    (in_req),
    .full        (full),
    .pop         (pop),
    .res_o       (res),
    .empty       (empty),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ccte_epoch_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_req_i    (in_req),
    .full        (full),
    .pop         (pop),
    .res_i       (res),
    .empty       (empty),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .n_fail_o    (n_fail),
    .n_due_o     (n_due),
    .n_checked_o (n_checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, n_due);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_asked != hold_done) begin
      hold_left = HoldCycles;
      hold_done = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic has, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push             <= 1'b1;
    in_req.char_byte <= ch;
    in_req.has_char  <= has;
    in_req.field_end <= fin;
    do @(posedge clk_i); while (full);
    if (has || fin) n_items++;
    if (fin) n_fields++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, fin && (i == s.len() - 1));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (n_due != 0) @(negedge clk_i);
  endtask

  task automatic write_format(input logic v);
    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_fmt = v;
  endtask

  task automatic add_digits(input int v, input int nd);
    int div;
    div = 1;
    repeat (nd - 1) div = div * 10;
    repeat (nd) begin
      field_txt = {field_txt, CharZero + 8'((v / div) % 10)};
      div = div / 10;
    end
  endtask

  task automatic add_sep(input logic [7:0] c);
    field_txt = {field_txt, (($urandom_range(11) == 0) ? 8'($urandom()) : c)};
  endtask

  function automatic int pick_val(input int lo, input int hi, input int wide_hi);
    return ($urandom_range(7) == 0) ? $urandom_range(wide_hi) : $urandom_range(hi, lo);
  endfunction

  task automatic send_random_field();
    int         roll;
    int         y;
    int         p;
    logic       use_ts;
    logic       empty_end;
    logic [7:0] c;
    field_txt.delete();
    roll   = $urandom_range(99);
    use_ts = ($urandom_range(9) == 0) ? !cur_fmt : cur_fmt;
    if (roll >= 94) begin
      repeat ($urandom_range(24)) field_txt = {field_txt, 8'($urandom())};
    end else begin
      case ($urandom_range(9))
        0:       y = 0;
        1:       y = 9999;
        default: y = $urandom_range(9999);
      endcase
      add_digits(y, 4);
      add_sep("-");
      if (roll >= 70 && roll < 80) begin
        add_digits(($urandom_range(3) == 0) ? 0 : $urandom_range(99, 13), 2);
      end else begin
        add_digits($urandom_range(12, 1), 2);
      end
      add_sep("-");
      add_digits(pick_val(1, 31, 99), 2);
      if (use_ts) begin
        add_sep(" ");
        add_digits(pick_val(0, 23, 99), 2);
        add_sep(":");
        add_digits(pick_val(0, 59, 99), 2);
        add_sep(":");
        add_digits(pick_val(0, 59, 99), 2);
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(8, 1)) field_txt = {field_txt, 8'($urandom())};
      end
      if (roll >= 80 && roll < 88) begin
        do p = $urandom_range(field_txt.size() - 1);
        while (p == 4 || p == 7 || p == 10 || p == 13 || p == 16);
        do c = 8'($urandom()); while (c >= CharZero && c <= CharNine);
        field_txt[p] = c;
      end
      if (roll >= 88) begin
        p = $urandom_range(field_txt.size() - 1);
        while (field_txt.size() > p) void'(field_txt.pop_back());
      end
    end
    empty_end = (field_txt.size() == 0) || ($urandom_range(7) == 0);
    foreach (field_txt[i]) begin
      if ($urandom_range(15) == 0) send_item(8'($urandom()), 1'b0, 1'b0);
      send_item(field_txt[i], 1'b1, !empty_end && (i == field_txt.size() - 1));
    end
    if (empty_end) send_item(8'($urandom()), 1'b0, 1'b1);
  endtask

  initial begin
    int phase_items;
    int phase_fields;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // date format
    write_format(1'b0);
    send_text("1970-01-01", 1'b1);
    send_text("0000-01-01", 1'b1);
    send_text("9999-12-31", 1'b1);
    send_text("2000-02-29", 1'b1);
    send_text("1969-12-31", 1'b1);
    send_text("2024-00-10", 1'b1);
    send_text("2024-13-01", 1'b1);
    send_text("20a4-01-01", 1'b1);
    send_text("2024-01", 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_text("1999-07-04", 1'b1);
    send_text("12x4-1", 1'b1);
    send_text("2024-13-0x", 1'b1);
    send_text("2023-02-99", 1'b1);
    send_text("2024-05-06 12:00:00", 1'b1);
    send_text("2024", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_text("05-06", 1'b1);
    // length limit follows the format at arrival time
    send_text("2000-01-01 1", 1'b0);

    // timestamp format
    write_format(1'b1);
    send_text("2:34:56", 1'b1);
    send_text("1970-01-01 00:00:00", 1'b1);
    send_text("0000-01-00 00:00:00", 1'b1);
    send_text("9999-12-99 99:99:99", 1'b1);
    send_text("2024-01-01", 1'b1);
    send_text("2024-01-01 12:3a:00", 1'b1);
    send_text("2024-01-01 00:00:00ZZZZZZ", 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_format(p[0]);
      case (p / 2)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 78; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 78; end
        default: begin sender_idle_pct = 16; stall_pct = 16; end
      endcase
      if (p == 0) begin
        // hold the output back and keep pushing fields until input backs up
        hold_asked++;
        repeat (12) begin
          if ($urandom_range(1) == 0) send_item(8'($urandom()), 1'b0, 1'b1);
          else send_text("1", 1'b1);
        end
      end
      phase_items  = n_items;
      phase_fields = n_fields;
      while (n_items - phase_items < 12 || n_fields - phase_fields < 1) begin
        send_random_field();
        if (p == 4 && n_fields - phase_fields == 1) drain_results();
      end
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    $display("%0d fields, %0d characters, date and timestamp formats, four idle/stall mixes",
             n_fields, n_items);
    $display("%0d results checked, one output hold-off of %0d cycles", n_checked, HoldCycles);
    if (n_fail == 0 && n_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ccte_pkg.sv
rtl/ccte_front.sv
rtl/ccte_queue.sv
rtl/ccte_back.sv
rtl/civil_date_time_to_epoch.sv
rtl/ccte_checker.sv
tb/ccte_epoch_checker.sv
tb/tb.sv
